>>> src/otb_pkg.sv
// Shared types and default sizes for the Otsu threshold binarizer.
package otb_pkg;

	localparam int LEVELS_DEF     = 256;
	localparam int COUNT_BITS_DEF = 23;

	localparam logic OP_HISTOGRAM = 1'b0;
	localparam logic OP_BINARIZE  = 1'b1;

	typedef struct packed {
		logic       operation;
		logic [7:0] pixel;
		logic       last;
	} pixel_req_t;

	typedef struct packed {
		logic       binary_value;
		logic [7:0] threshold;
		logic       threshold_ready;
	} result_t;

endpackage

>>> src/otb_stream_if.sv
// Valid/ready stream channel carrying one request per handshake.
interface otb_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> src/otb_mul.sv
// Iterative shift-add multiplier, one multiplier bit per cycle.
module otb_mul #(
	parameter int AW = 108,
	parameter int BW = 54
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [AW-1:0]   a,
	input  logic [BW-1:0]   b,
	output logic            done,
	output logic [AW+BW-1:0] product
);
	localparam int PW = AW + BW;
	localparam int CW = $clog2(BW + 1);

	logic [PW-1:0] acc_q;
	logic [PW-1:0] a_q;
	logic [BW-1:0] b_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CW'(BW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= PW'(a);
			b_q   <= b;
		end else if (cnt_q != '0) begin
			if (b_q[0]) acc_q <= acc_q + a_q;
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

	assign done    = done_q;
	assign product = acc_q;
endmodule

>>> src/otb_hist.sv
// Histogram memory: increment pipeline with forwarding, sweep read-and-clear, reset clear pass.
module otb_hist #(
	parameter int LEVELS     = 256,
	parameter int COUNT_BITS = 23
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      inc_en,
	input  logic [$clog2(LEVELS)-1:0] inc_bin,
	input  logic                      sw_en,
	input  logic [$clog2(LEVELS)-1:0] sw_addr,
	output logic [COUNT_BITS-1:0]     rd_data,
	output logic                      busy
);
	localparam int LB = $clog2(LEVELS);

	logic [COUNT_BITS-1:0] mem [LEVELS];
	logic [COUNT_BITS-1:0] rd_q;

	logic                  valid_s1;
	logic [LB-1:0]         bin_s1;
	logic                  fwd_hit_s1;
	logic [COUNT_BITS-1:0] fwd_val_s1;

	logic                  clr_busy_q;
	logic [LB-1:0]         clr_addr_q;

	logic                  we;
	logic [LB-1:0]         wa;
	logic [COUNT_BITS-1:0] wd;
	logic                  re;
	logic [LB-1:0]         ra;
	logic [COUNT_BITS-1:0] inc_val;

	assign inc_val = (fwd_hit_s1 ? fwd_val_s1 : rd_q) + 1'b1;
	assign we = clr_busy_q | sw_en | valid_s1;
	assign wa = clr_busy_q ? clr_addr_q : (sw_en ? sw_addr : bin_s1);
	assign wd = (clr_busy_q | sw_en) ? '0 : inc_val;
	assign re = sw_en | inc_en;
	assign ra = sw_en ? sw_addr : inc_bin;

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		if (re) rd_q <= mem[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			fwd_hit_s1 <= 1'b0;
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else begin
			valid_s1   <= inc_en;
			fwd_hit_s1 <= valid_s1 && inc_en && (inc_bin == bin_s1);
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == LB'(LEVELS - 1)) clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		bin_s1     <= inc_bin;
		fwd_val_s1 <= inc_val;
	end

	assign rd_data = rd_q;
	assign busy    = clr_busy_q;
endmodule

>>> src/otb_sweep.sv
// Threshold sweep sequencer: walks the histogram, exact variance compare on a shared multiplier.
module otb_sweep #(
	parameter int LEVELS     = 256,
	parameter int COUNT_BITS = 23
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [COUNT_BITS-1:0]     n,
	input  logic [COUNT_BITS+7:0]     s,
	input  logic [COUNT_BITS-1:0]     rd_data,
	output logic                      sw_en,
	output logic [$clog2(LEVELS)-1:0] sw_addr,
	output logic                      busy,
	output logic                      done,
	output logic [7:0]                level
);
	localparam int LB  = $clog2(LEVELS);
	localparam int CB  = COUNT_BITS;
	localparam int MW  = CB + 8;
	localparam int XW  = 2 * CB + 8;
	localparam int QW  = 4 * CB + 16;
	localparam int DW  = 2 * CB;
	localparam int AW  = QW;
	localparam int BW  = XW;
	localparam int PW  = AW + BW;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_WAIT = 4'd1;
	localparam logic [3:0] S_RD   = 4'd2;
	localparam logic [3:0] S_ACC  = 4'd3;
	localparam logic [3:0] S_CHK  = 4'd4;
	localparam logic [3:0] S_MST  = 4'd5;
	localparam logic [3:0] S_MRUN = 4'd6;
	localparam logic [3:0] S_CMP  = 4'd7;
	localparam logic [3:0] S_DONE = 4'd8;

	localparam logic [2:0] M_SW  = 3'd0;
	localparam logic [2:0] M_MN  = 3'd1;
	localparam logic [2:0] M_SQ  = 3'd2;
	localparam logic [2:0] M_DEN = 3'd3;
	localparam logic [2:0] M_LHS = 3'd4;
	localparam logic [2:0] M_RHS = 3'd5;

	logic [3:0]    state_q;
	logic [2:0]    mstep_q;
	logic [LB-1:0] k_q;
	logic [CB-1:0] w_q;
	logic [MW-1:0] m_q;
	logic [XW-1:0] sw_q;
	logic [XW-1:0] mn_q;
	logic [QW-1:0] sq_q;
	logic [DW-1:0] den_q;
	logic [PW-1:0] lhs_q;
	logic [PW-1:0] rhs_q;
	logic [QW-1:0] best_sq_q;
	logic [DW-1:0] best_den_q;
	logic [7:0]    win_q;

	logic          mul_start;
	logic          mul_done;
	logic [AW-1:0] mul_a;
	logic [BW-1:0] mul_b;
	logic [PW-1:0] mul_p;
	logic [XW-1:0] diff;

	assign diff = (sw_q >= mn_q) ? (sw_q - mn_q) : (mn_q - sw_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (mstep_q)
			M_SW: begin
				mul_a = AW'(s);
				mul_b = BW'(w_q);
			end
			M_MN: begin
				mul_a = AW'(m_q);
				mul_b = BW'(n);
			end
			M_SQ: begin
				mul_a = AW'(diff);
				mul_b = diff;
			end
			M_DEN: begin
				mul_a = AW'(w_q);
				mul_b = BW'(n - w_q);
			end
			M_LHS: begin
				mul_a = sq_q;
				mul_b = BW'(best_den_q);
			end
			M_RHS: begin
				mul_a = best_sq_q;
				mul_b = BW'(den_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_start = (state_q == S_MST);

	otb_mul #(.AW(AW), .BW(BW)) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (mul_a),
		.b       (mul_b),
		.done    (mul_done),
		.product (mul_p)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mstep_q <= M_SW;
			k_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) state_q <= S_WAIT;
					k_q <= '0;
				end
				S_WAIT: state_q <= S_RD;
				S_RD:   state_q <= S_ACC;
				S_ACC:  state_q <= S_CHK;
				S_CHK: begin
					mstep_q <= M_SW;
					if (w_q == '0 || w_q >= n) begin
						if (k_q == LB'(LEVELS - 1)) state_q <= S_DONE;
						else begin
							k_q     <= k_q + 1'b1;
							state_q <= S_RD;
						end
					end else begin
						state_q <= S_MST;
					end
				end
				S_MST: state_q <= S_MRUN;
				S_MRUN: begin
					if (mul_done) begin
						if (mstep_q == M_RHS) state_q <= S_CMP;
						else begin
							mstep_q <= mstep_q + 1'b1;
							state_q <= S_MST;
						end
					end
				end
				S_CMP: begin
					if (k_q == LB'(LEVELS - 1)) state_q <= S_DONE;
					else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				w_q        <= '0;
				m_q        <= '0;
				best_sq_q  <= '0;
				best_den_q <= DW'(1);
				win_q      <= '0;
			end
			S_ACC: begin
				w_q <= w_q + rd_data;
				m_q <= m_q + MW'(k_q) * MW'(rd_data);
			end
			S_MRUN: begin
				if (mul_done) begin
					case (mstep_q)
						M_SW:    sw_q  <= XW'(mul_p);
						M_MN:    mn_q  <= XW'(mul_p);
						M_SQ:    sq_q  <= QW'(mul_p);
						M_DEN:   den_q <= DW'(mul_p);
						M_LHS:   lhs_q <= mul_p;
						M_RHS:   rhs_q <= mul_p;
						default: lhs_q <= lhs_q;
					endcase
				end
			end
			S_CMP: begin
				if (lhs_q > rhs_q) begin
					best_sq_q  <= sq_q;
					best_den_q <= den_q;
					win_q      <= 8'(k_q);
				end
			end
			default: win_q <= win_q;
		endcase
	end

	assign sw_en   = (state_q == S_RD);
	assign sw_addr = k_q;
	assign busy    = (state_q != S_IDLE);
	assign done    = (state_q == S_DONE);
	assign level   = win_q;
endmodule

>>> src/otsu_threshold_binarizer.sv
// Otsu threshold binarizer top level: request handling, totals, threshold and result register.
//
// pixels carries requests {operation, pixel, last}; results carries
// {binary_value, threshold, threshold_ready}. Both are valid/ready channels.
// Histogram requests are taken one per cycle while pixels.ready is high and
// give no result, except the one marked last: it starts the sweep and yields
// one threshold result. The sweep visits every level, reading and clearing
// its bin. A level with an empty or full lower class skips the variance
// compare; any other runs its variance products in turn on the shared
// bit-serial multiplier. Binarize requests give one result each, one per
// cycle while pixels.ready is high; the result is registered and valid in
// the cycle after the request is taken. After reset the histogram memory
// is cleared while pixels.ready stays low. The result register holds its
// result while the receiver stalls; no new request is taken until that
// result is taken or is being taken in the same cycle.
module otsu_threshold_binarizer #(
	parameter int LEVELS     = otb_pkg::LEVELS_DEF,
	parameter int COUNT_BITS = otb_pkg::COUNT_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	otb_stream_if.sink   pixels,
	otb_stream_if.source results
);
	import otb_pkg::*;

	localparam int LB = $clog2(LEVELS);
	localparam int CB = COUNT_BITS;
	localparam int MW = CB + 8;

	logic          out_valid_q;
	result_t       out_q;
	logic [CB-1:0] total_q;
	logic [MW-1:0] sum_q;
	logic [7:0]    thr_q;

	logic          accept;
	logic          hist_busy;
	logic          sweep_busy;
	logic          sweep_done;
	logic [7:0]    sweep_level;
	logic          inc_en;
	logic [LB-1:0] bin;
	logic          sw_en;
	logic [LB-1:0] sw_addr;
	logic [CB-1:0] rd_data;
	pixel_req_t    req;

	assign req = pixels.data;
	assign pixels.ready = !hist_busy && !sweep_busy && (!out_valid_q || results.ready);
	assign accept = pixels.valid && pixels.ready;
	assign bin = ({1'b0, req.pixel} < 9'(LEVELS)) ? LB'(req.pixel) : LB'(LEVELS - 1);
	assign inc_en = accept && (req.operation == OP_HISTOGRAM) && (total_q != {CB{1'b1}});

	otb_hist #(.LEVELS(LEVELS), .COUNT_BITS(COUNT_BITS)) u_hist (
		.clk     (clk),
		.arst_n  (arst_n),
		.inc_en  (inc_en),
		.inc_bin (bin),
		.sw_en   (sw_en),
		.sw_addr (sw_addr),
		.rd_data (rd_data),
		.busy    (hist_busy)
	);

	otb_sweep #(.LEVELS(LEVELS), .COUNT_BITS(COUNT_BITS)) u_sweep (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (accept && (req.operation == OP_HISTOGRAM) && req.last),
		.n       (total_q),
		.s       (sum_q),
		.rd_data (rd_data),
		.sw_en   (sw_en),
		.sw_addr (sw_addr),
		.busy    (sweep_busy),
		.done    (sweep_done),
		.level   (sweep_level)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			total_q     <= '0;
			sum_q       <= '0;
			thr_q       <= '0;
		end else begin
			if (results.ready) out_valid_q <= 1'b0;
			if (inc_en) begin
				total_q <= total_q + 1'b1;
				sum_q   <= sum_q + MW'(bin);
			end
			if (accept && (req.operation == OP_BINARIZE)) out_valid_q <= 1'b1;
			if (sweep_done) begin
				thr_q       <= sweep_level;
				total_q     <= '0;
				sum_q       <= '0;
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (req.operation == OP_BINARIZE)) begin
			out_q.binary_value    <= (req.pixel >= thr_q);
			out_q.threshold       <= thr_q;
			out_q.threshold_ready <= 1'b0;
		end else if (sweep_done) begin
			out_q.binary_value    <= 1'b0;
			out_q.threshold       <= sweep_level;
			out_q.threshold_ready <= 1'b1;
		end
	end

	assign results.valid = out_valid_q;
	assign results.data  = out_q;
endmodule

>>> src/otb_checker.sv
// Port-level checks for the Otsu threshold binarizer, bound to the top level.
module otb_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic in_operation,
	input logic in_last,
	input logic out_valid,
	input logic out_ready,
	input logic out_binary_value,
	input logic out_threshold_ready
);
	import otb_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("request taken while result stalled");

	a_sweep_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_operation == OP_HISTOGRAM) && in_last |=> !in_ready)
		else $error("request taken during sweep");

	a_thr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_threshold_ready |-> !out_binary_value)
		else $error("threshold result with binary value set");
endmodule

bind otsu_threshold_binarizer otb_checker u_otb_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.in_valid            (pixels.valid),
	.in_ready            (pixels.ready),
	.in_operation        (pixels.data.operation),
	.in_last             (pixels.data.last),
	.out_valid           (results.valid),
	.out_ready           (results.ready),
	.out_binary_value    (results.data.binary_value),
	.out_threshold_ready (results.data.threshold_ready)
);
